[design/rgba_convolution_3x3_macros.svh]
// assertion macros shared by the rgba convolution modules
// expects clk and rst_n in the scope of each use
`ifndef RGBA_CONVOLUTION_3X3_MACROS_SVH
`define RGBA_CONVOLUTION_3X3_MACROS_SVH

// property checked on every rising clk edge outside reset
`define RC3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define RC3_ASSERT_NEVER(lbl, expr, msg) \
    `RC3_ASSERT(lbl, !(expr), msg)

`endif

[design/rc3_pkg.sv]
// shared types, constants and helpers of the rgba 3x3 convolution block
// no dependencies
package rc3_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 16;
    localparam int KROW_W     = 48;
    localparam int RECIP_W    = 24;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam int PIX_W       = 32;
    localparam int CH_W        = 8;
    localparam int TAPS        = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int WEIGHT_W    = 16;
    localparam int ACC_W       = 29;
    localparam int PROD_W      = ACC_W + RECIP_W;
    localparam int FRAC_BITS   = 24;
    localparam int SAT_MAX     = 255;

    localparam logic [IMG_W_W-1:0]  WIDTH_RST  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0]  HEIGHT_RST = IMG_H_W'(480);
    localparam logic [KROW_W-1:0]   KTOP_RST   = '0;
    localparam logic [KROW_W-1:0]   KMID_RST   = KROW_W'(16777216);
    localparam logic [KROW_W-1:0]   KBOT_RST   = '0;
    localparam logic [RECIP_W-1:0]  RECIP_RST  = RECIP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_KTOP   = 3'd2,
        REG_KMID   = 3'd3,
        REG_KBOT   = 3'd4,
        REG_RECIP  = 3'd5
    } rc3_reg_t;

    typedef enum logic {
        F_IDLE,
        F_LOAD
    } rc3_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MAC,
        B_SCALE,
        B_DONE
    } rc3_back_state_t;

    // one interior pixel's neighborhood in colour channels, with the centre alpha, row and last flag
    typedef struct packed {
        logic [TAPS-1:0][3*CH_W-1:0] pix;
        logic [CH_W-1:0]             alpha;
        logic [IMG_H_W-1:0]          row;
        logic                        last;
    } rc3_job_t;

    // filter coefficients, tap k at bits 16k
    typedef struct packed {
        logic [3*KROW_W-1:0]        weights;
        logic signed [RECIP_W-1:0]  recip;
    } rc3_coef_t;

    function automatic logic [CH_W-1:0] rc3_clamp(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-FRAC_BITS-1:0] q;
        begin
            q = p[PROD_W-1:FRAC_BITS];
            if (p[PROD_W-1])
                return '0;
            else if (q > (PROD_W-FRAC_BITS)'(SAT_MAX))
                return CH_W'(SAT_MAX);
            else
                return q[CH_W-1:0];
        end
    endfunction

endpackage

[design/rc3_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module rc3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/rc3_fifo.sv]
// small register queue between the front and back of the convolution block
// uses rc3_pkg and the assertion macros
`include "rgba_convolution_3x3_macros.svh"

module rc3_fifo
    import rc3_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    `RC3_ASSERT_NEVER(a_no_overflow, push && full, "front pushed into a full queue")
    `RC3_ASSERT(a_count_bound, count_reg <= NW'(DEPTH), "queue count beyond depth")

endmodule

[design/rc3_front.sv]
// front end: position counters, two line stores and the 3x3 window
// uses rc3_pkg and rc3_ram
module rc3_front
    import rc3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [CH_W-1:0]              red,
    input  logic [CH_W-1:0]              green,
    input  logic [CH_W-1:0]              blue,
    input  logic [CH_W-1:0]              alpha,
    input  logic                         frame_start,
    input  logic [IMG_W_W-1:0]           image_width,
    input  logic [IMG_H_W-1:0]           image_height,
    input  logic                         q_full,
    output logic                         q_push,
    output rc3_job_t                     job,
    output logic [$clog2(MAX_WIDTH)-1:0] job_col
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

    rc3_front_state_t   state_reg, state_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [IMG_H_W-1:0] row_reg, row_next;
    logic [CW-1:0]      cpos_reg;
    logic [IMG_H_W-1:0] rpos_reg;
    logic               last_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   win_reg  [TAPS];
    logic [PIX_W-1:0]   win_next [TAPS];

    logic               accept;
    logic [CW-1:0]      c_eff;
    logic [IMG_H_W-1:0] r_eff;
    logic [XW-1:0]      w_ext, w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic               col_wrap, row_wrap, emit;
    logic [PIX_W-1:0]   top_rdata, mid_rdata;

    assign accept = (state_reg == F_IDLE) && push && !q_full;
    assign full   = (state_reg != F_IDLE) || q_full;

    assign c_eff = frame_start ? '0 : col_reg;
    assign r_eff = frame_start ? '0 : row_reg;
    assign w_ext = XW'(image_width);
    assign w_eff = (w_ext == '0) ? XW'(1)
                 : (w_ext > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : w_ext;
    assign h_eff = (image_height == '0) ? IMG_H_W'(1) : image_height;

    assign col_wrap = (XW'(c_eff) + XW'(1)) >= w_eff;
    assign row_wrap = ({1'b0, r_eff} + (IMG_H_W + 1)'(1)) >= {1'b0, h_eff};

    // line stores, read at accept, written back when the read data returns
    rc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (state_reg == F_LOAD),
        .waddr (cpos_reg),
        .wdata (mid_rdata),
        .raddr (c_eff),
        .rdata (top_rdata)
    );

    rc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (state_reg == F_LOAD),
        .waddr (cpos_reg),
        .wdata (pix_reg),
        .raddr (c_eff),
        .rdata (mid_rdata)
    );

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top_rdata;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid_rdata;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = pix_reg;
    end

    assign emit   = (cpos_reg >= CW'(2)) && (rpos_reg >= IMG_H_W'(2));
    assign q_push = (state_reg == F_LOAD) && emit;

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
            job.pix[k] = win_next[k][3*CH_W-1:0];
        job.alpha = win_next[4][PIX_W-1:3*CH_W];
        job.row   = rpos_reg - 1'b1;
        job.last  = last_reg;
    end

    assign job_col = cpos_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_LOAD;
                    if (col_wrap)
                    begin
                        col_next = '0;
                        row_next = row_wrap ? '0 : r_eff + 1'b1;
                    end
                    else
                    begin
                        col_next = c_eff + 1'b1;
                        row_next = r_eff;
                    end
                end
            end
            F_LOAD:
                state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= {alpha, blue, green, red};
            cpos_reg <= c_eff;
            rpos_reg <= r_eff;
            last_reg <= col_wrap && row_wrap;
        end
        if (state_reg == F_LOAD)
        begin
            for (int k = 0; k < TAPS; k++)
                win_reg[k] <= win_next[k];
        end
    end

endmodule

[design/rc3_back.sv]
// back end: weighted sum per channel, reciprocal scaling, clamp, result register
// uses rc3_pkg and the assertion macros
`include "rgba_convolution_3x3_macros.svh"

module rc3_back
    import rc3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  rc3_job_t                     job,
    input  logic [$clog2(MAX_WIDTH)-1:0] job_col,
    input  rc3_coef_t                    coef,
    output logic                         empty,
    input  logic                         pop,
    output logic [CH_W-1:0]              out_red,
    output logic [CH_W-1:0]              out_green,
    output logic [CH_W-1:0]              out_blue,
    output logic [CH_W-1:0]              out_alpha,
    output logic [$clog2(MAX_WIDTH)-1:0] out_column,
    output logic [IMG_H_W-1:0]           out_row,
    output logic                         frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int TW = $clog2(TAPS);

    rc3_back_state_t          state_reg, state_next;
    rc3_job_t                 job_reg;
    logic [CW-1:0]            col_reg;
    logic [TW-1:0]            tap_reg;
    logic signed [ACC_W-1:0]  acc_reg  [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic [CH_W-1:0]          res_ch_reg [3];
    logic [CH_W-1:0]          res_alpha_reg;
    logic [CW-1:0]            res_col_reg;
    logic [IMG_H_W-1:0]       res_row_reg;
    logic                     res_last_reg;
    logic                     res_valid_reg;

    logic                     res_load;
    logic [3*CH_W-1:0]        tap_pix;
    logic signed [WEIGHT_W-1:0]     tap_w;
    logic signed [CH_W+WEIGHT_W:0]  mterm [3];

    assign tap_pix = job_reg.pix[tap_reg];
    assign tap_w   = coef.weights[tap_reg*WEIGHT_W +: WEIGHT_W];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            mterm[ch] = $signed({1'b0, tap_pix[ch*CH_W +: CH_W]}) * tap_w;
    end

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign res_load = (state_reg == B_DONE) && (!res_valid_reg || pop);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                    state_next = B_MAC;
            B_MAC:
                if (tap_reg == TW'(TAPS - 1))
                    state_next = B_SCALE;
            B_SCALE:
                state_next = B_DONE;
            B_DONE:
                if (res_load)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (pop)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg <= job;
                col_reg <= job_col;
                tap_reg <= '0;
                for (int ch = 0; ch < 3; ch++)
                    acc_reg[ch] <= '0;
            end
            B_MAC:
            begin
                tap_reg <= tap_reg + 1'b1;
                for (int ch = 0; ch < 3; ch++)
                    acc_reg[ch] <= acc_reg[ch] + ACC_W'(mterm[ch]);
            end
            B_SCALE:
            begin
                for (int ch = 0; ch < 3; ch++)
                    prod_reg[ch] <= acc_reg[ch] * coef.recip;
            end
            default:
            begin
            end
        endcase
        if (res_load)
        begin
            for (int ch = 0; ch < 3; ch++)
                res_ch_reg[ch] <= rc3_clamp(prod_reg[ch]);
            res_alpha_reg <= job_reg.alpha;
            res_col_reg   <= col_reg;
            res_row_reg   <= job_reg.row;
            res_last_reg  <= job_reg.last;
        end
    end

    assign empty      = !res_valid_reg;
    assign out_red    = res_ch_reg[0];
    assign out_green  = res_ch_reg[1];
    assign out_blue   = res_ch_reg[2];
    assign out_alpha  = res_alpha_reg;
    assign out_column = res_col_reg;
    assign out_row    = res_row_reg;
    assign frame_last = res_last_reg;

    `RC3_ASSERT(a_res_held, res_valid_reg && !pop |=> res_valid_reg, "waiting result dropped")
    `RC3_ASSERT(a_pop_starts_mac, q_pop |=> state_reg == B_MAC, "queue pop did not start a job")

endmodule

[design/rgba_convolution_3x3.sv]
// rgba 3x3 convolution filter top level: config registers, front, queue, back
// uses rc3_pkg, rc3_front, rc3_fifo, rc3_back
//
// pixels enter in raster order on push/full, one per accepted push; frame_start
// marks row 0, column 0. only interior pixels produce a result, taken with
// pop while empty is low; out_column/out_row give its position, frame_last
// flags the last interior pixel of the frame.
// the front takes a pixel while idle (line store read) and writes the line
// stores back in the load state before it can take the next pixel; the back
// handles one result at a time: a dequeue, a multiply-accumulate step per window
// tap, a reciprocal multiply and a clamp into the result register, and only then
// dequeues the next job. a 4-entry job queue sits between front and back; when
// the receiver stalls, the result register holds, the back waits, the queue
// fills and then full rises. reset clears counters and handshake state; line
// stores and window are not cleared and fill as the first two lines arrive.
// the user must write config through cfg_write/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this.
module rgba_convolution_3x3
    import rc3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [CH_W-1:0]              red,
    input  logic [CH_W-1:0]              green,
    input  logic [CH_W-1:0]              blue,
    input  logic [CH_W-1:0]              alpha,
    input  logic                         frame_start,
    output logic                         empty,
    input  logic                         pop,
    output logic [CH_W-1:0]              out_red,
    output logic [CH_W-1:0]              out_green,
    output logic [CH_W-1:0]              out_blue,
    output logic [CH_W-1:0]              out_alpha,
    output logic [$clog2(MAX_WIDTH)-1:0] out_column,
    output logic [IMG_H_W-1:0]           out_row,
    output logic                         frame_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int JOB_W = $bits(rc3_job_t) + CW;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [KROW_W-1:0]  ktop_reg, kmid_reg, kbot_reg;
    logic [RECIP_W-1:0] recip_reg;

    rc3_coef_t       coef;
    rc3_job_t        f_job, b_job;
    logic [CW-1:0]   f_col, b_col;
    logic            q_push, q_pop, q_full, q_empty;
    logic [JOB_W-1:0] q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            ktop_reg   <= KTOP_RST;
            kmid_reg   <= KMID_RST;
            kbot_reg   <= KBOT_RST;
            recip_reg  <= RECIP_RST;
        end
        else if (cfg_write)
        begin
            case (rc3_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                REG_KTOP:   ktop_reg   <= cfg_data[KROW_W-1:0];
                REG_KMID:   kmid_reg   <= cfg_data[KROW_W-1:0];
                REG_KBOT:   kbot_reg   <= cfg_data[KROW_W-1:0];
                REG_RECIP:  recip_reg  <= cfg_data[RECIP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign coef.weights = {kbot_reg, kmid_reg, ktop_reg};
    assign coef.recip   = recip_reg;

    rc3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .frame_start  (frame_start),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .job          (f_job),
        .job_col      (f_col)
    );

    rc3_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({f_job, f_col}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign b_job = q_rdata[JOB_W-1:CW];
    assign b_col = q_rdata[CW-1:0];

    rc3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .job        (b_job),
        .job_col    (b_col),
        .coef       (coef),
        .empty      (empty),
        .pop        (pop),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .out_column (out_column),
        .out_row    (out_row),
        .frame_last (frame_last)
    );

endmodule
